### sv/brb_pkg.sv
// brb_pkg: shared types and codes for the broadcast ring buffer.
// No dependencies; imported by brb_ctrl, brb_dp and broadcast_ring_buffer.
package brb_pkg;

	localparam int DATA_BITS     = 8;
	localparam int RID_BITS      = 5;
	localparam int SCFG_BITS     = 5;
	localparam int RCFG_BITS     = 6;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 6;

	// response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_BADID = 2'd3;

	// request opcodes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// config register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOTS   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_READERS = 2'd1;

	typedef struct packed {
		logic                cmd;
		logic [DATA_BITS-1:0] write_value;
		logic [RID_BITS-1:0]  reader_id;
	} in_item_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] read_data;
		logic [1:0]           status;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch request, launch read pointer lookup
		logic eval;      // slot lookup, decide status, commit write / read pointer
		logic count;     // update read count of the slot, maybe free it
		logic load_out;  // move result into the response register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;       // read request found a ready word (valid during eval)
		logic out_free;  // response register can take a result this cycle
	} dp_stat_t;

endpackage

### sv/brb_ctrl.sv
// brb_ctrl: request sequencer for the broadcast ring buffer.
// Depends on brb_pkg (dp_cmd_t, dp_stat_t).
module brb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output brb_pkg::dp_cmd_t  dp_cmd,
	input  brb_pkg::dp_stat_t dp_stat
);
	import brb_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_IDX  = 2'd1;
	localparam logic [1:0] S_CNT  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nxt = S_IDX;
			end
			S_IDX: begin
				state_nxt = dp_stat.hit ? S_CNT : S_OUT;
			end
			S_CNT: begin
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (dp_stat.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall        = (state_q != S_IDLE);
	assign dp_cmd.capture   = (state_q == S_IDLE) && req_valid;
	assign dp_cmd.eval      = (state_q == S_IDX);
	assign dp_cmd.count     = (state_q == S_CNT);
	assign dp_cmd.load_out  = (state_q == S_OUT) && dp_stat.out_free;

endmodule

### sv/brb_dp.sv
// brb_dp: storage and per-request datapath of the broadcast ring buffer.
// Data and read-count memories, read pointer memory, ready/free bits, response reg.
// Depends on brb_pkg.
module brb_dp #(
	parameter int SLOTS   = 16,
	parameter int READERS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [brb_pkg::SCFG_BITS-1:0]      cfg_slots,
	input  logic [brb_pkg::RCFG_BITS-1:0]      cfg_readers,
	input  brb_pkg::in_item_t                  req,
	input  brb_pkg::dp_cmd_t                   dp_cmd,
	output brb_pkg::dp_stat_t                  dp_stat,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output brb_pkg::out_item_t                 rsp
);
	import brb_pkg::*;

	localparam int SIDX_W = $clog2(SLOTS);
	localparam int RID_W  = (READERS > 1) ? $clog2(READERS) : 1;
	localparam int RCNT_W = $clog2(READERS + 1);
	localparam int SLIM_W = ($clog2(SLOTS + 1) > SCFG_BITS) ? $clog2(SLOTS + 1) : SCFG_BITS;
	localparam int RLIM_W = (RCNT_W > RCFG_BITS) ? RCNT_W : RCFG_BITS;

	// effective limits, clamped to 1..SLOTS and 1..READERS
	logic [SLIM_W-1:0] slots_ext;
	logic [SLIM_W-1:0] eff_slots;
	logic [RLIM_W-1:0] readers_ext;
	logic [RLIM_W-1:0] nread;

	always_comb begin
		slots_ext   = SLIM_W'(cfg_slots);
		readers_ext = RLIM_W'(cfg_readers);
		if (slots_ext == '0)
			eff_slots = SLIM_W'(1);
		else if (slots_ext > SLIM_W'(SLOTS))
			eff_slots = SLIM_W'(SLOTS);
		else
			eff_slots = slots_ext;
		if (readers_ext == '0)
			nread = RLIM_W'(1);
		else if (readers_ext > RLIM_W'(READERS))
			nread = RLIM_W'(READERS);
		else
			nread = readers_ext;
	end

	function automatic logic [SIDX_W-1:0] next_idx(input logic [SIDX_W-1:0] idx,
			input logic [SLIM_W-1:0] lim);
		logic [SLIM_W-1:0] n;
		n = SLIM_W'(idx) + SLIM_W'(1);
		return (n >= lim) ? '0 : idx + SIDX_W'(1);
	endfunction

	// state
	in_item_t              req_q;
	logic [SIDX_W-1:0]     wr_idx_q;
	logic [SLOTS-1:0]      slot_free_q;
	logic [SLOTS-1:0]      ready_q [READERS];
	logic [SIDX_W-1:0]     ridx_mem [READERS];
	logic [READERS-1:0]    ridx_vld_q;
	logic [SIDX_W-1:0]     ridx_rd_q;
	logic [DATA_BITS-1:0]  data_mem [SLOTS];
	logic [DATA_BITS-1:0]  data_rd_q;
	logic [RCNT_W-1:0]     done_mem [SLOTS];
	logic [RCNT_W-1:0]     done_rd_q;
	logic [SIDX_W-1:0]     slot_q;
	logic                  hit_q;
	logic [1:0]            res_status_q;
	logic                  rsp_valid_q;
	out_item_t             rsp_q;

	// per-request decode
	logic [RID_W-1:0]      rid_idx;
	logic                  is_write;
	logic                  bad_id;
	logic [SIDX_W-1:0]     r_slot;
	logic                  ready_bit;
	logic                  wr_free;
	logic                  wr_ok;
	logic                  hit;
	logic                  rd_commit;
	logic [RCNT_W-1:0]     cnt_inc;
	logic                  freed;
	logic [READERS-1:0]    set_mask;
	logic [1:0]            status_nxt;

	always_comb begin
		rid_idx   = RID_W'(req_q.reader_id);
		is_write  = (req_q.cmd == CMD_WRITE);
		bad_id    = (RLIM_W'(req_q.reader_id) >= nread);
		r_slot    = ridx_vld_q[rid_idx] ? ridx_rd_q : '0;
		ready_bit = ready_q[rid_idx][r_slot];
		wr_free   = slot_free_q[wr_idx_q];
		wr_ok     = dp_cmd.eval && is_write && wr_free;
		hit       = !is_write && !bad_id && ready_bit;
		rd_commit = dp_cmd.eval && hit;
		cnt_inc   = done_rd_q + RCNT_W'(1);
		freed     = (RLIM_W'(cnt_inc) >= nread);
		for (int j = 0; j < READERS; j++) begin
			set_mask[j] = (RLIM_W'(j) < nread);
		end
		priority if (is_write)
			status_nxt = wr_free ? ST_OK : ST_FULL;
		else if (bad_id)
			status_nxt = ST_BADID;
		else if (ready_bit)
			status_nxt = ST_OK;
		else
			status_nxt = ST_EMPTY;
	end

	// request latch, per-request scratch registers
	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			req_q     <= req;
			ridx_rd_q <= ridx_mem[RID_W'(req.reader_id)];
		end
		if (dp_cmd.eval) begin
			slot_q       <= r_slot;
			hit_q        <= hit;
			res_status_q <= status_nxt;
		end
	end

	// read pointer memory
	always_ff @(posedge clk) begin
		if (rd_commit) ridx_mem[rid_idx] <= next_idx(r_slot, eff_slots);
	end

	// data memory
	always_ff @(posedge clk) begin
		if (wr_ok) data_mem[wr_idx_q] <= req_q.write_value;
		if (dp_cmd.eval) data_rd_q <= data_mem[r_slot];
	end

	// read count memory; cleared on every write of its slot, so never read unwritten
	always_ff @(posedge clk) begin
		if (wr_ok)
			done_mem[wr_idx_q] <= '0;
		else if (dp_cmd.count)
			done_mem[slot_q] <= freed ? '0 : cnt_inc;
		if (dp_cmd.eval) done_rd_q <= done_mem[r_slot];
	end

	// control state with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			slot_free_q <= '1;
			ridx_vld_q  <= '0;
			for (int j = 0; j < READERS; j++) ready_q[j] <= '0;
		end else begin
			if (wr_ok) begin
				wr_idx_q              <= next_idx(wr_idx_q, eff_slots);
				slot_free_q[wr_idx_q] <= 1'b0;
				for (int j = 0; j < READERS; j++) begin
					if (set_mask[j]) ready_q[j][wr_idx_q] <= 1'b1;
				end
			end
			if (rd_commit) begin
				ready_q[rid_idx][r_slot] <= 1'b0;
				ridx_vld_q[rid_idx]      <= 1'b1;
			end
			if (dp_cmd.count && freed) slot_free_q[slot_q] <= 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dp_cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_out) begin
			rsp_q.read_data <= hit_q ? data_rd_q : '0;
			rsp_q.status    <= res_status_q;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp              = rsp_q;
	assign dp_stat.hit      = hit;
	assign dp_stat.out_free = !rsp_valid_q || !rsp_stall;

	// accepted write takes its slot out of the free set
	a_write_busies_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ok |=> !slot_free_q[$past(wr_idx_q)])
		else $error("slot still free after accepted write");

	// write pointer moves only on an accepted write
	a_wr_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_ok |=> $stable(wr_idx_q))
		else $error("write index moved without accepted write");

	// read count update follows only a successful read
	a_count_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.count |-> hit_q)
		else $error("read count update without a hit");

	// any non-ok response carries zero data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_OK) |-> (rsp_q.read_data == '0))
		else $error("non-ok response with nonzero data");

endmodule

### sv/broadcast_ring_buffer.sv
// broadcast_ring_buffer: top level, config registers plus controller and datapath.
// Depends on brb_pkg, brb_ctrl, brb_dp.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  req     | req_valid / req_stall | brb_pkg::in_item_t  (cmd, value, reader)
//  rsp     | rsp_valid / rsp_stall | brb_pkg::out_item_t (read_data, status)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time. Accept, read pointer lookup, slot lookup with status
// decision, then the result enters the response register; a successful read
// takes an extra step before that, which updates the slot's read count. The
// chain read pointer memory -> slot memories sets this order. A new request is
// taken once the result is in the response register; no two requests overlap.
// A stalled response holds in its register; the controller waits in its last
// state until the register frees. Reset is immediate: no memory clearing pass
// (read pointers carry valid bits, read counts are cleared on every write).
// Config writes are always taken (cfg_ready tied high); indexes past the list
// are ignored.
module broadcast_ring_buffer #(
	parameter int SLOTS   = 16,
	parameter int READERS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  brb_pkg::in_item_t                  req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output brb_pkg::out_item_t                 rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [brb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [brb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import brb_pkg::*;

	// config registers; raw values, clamping happens in the datapath
	logic [SCFG_BITS-1:0] slots_cfg_q;
	logic [RCFG_BITS-1:0] readers_cfg_q;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q   <= SCFG_BITS'(16);
			readers_cfg_q <= RCFG_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SLOTS:   slots_cfg_q   <= cfg_data[SCFG_BITS-1:0];
				CFG_READERS: readers_cfg_q <= cfg_data[RCFG_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: one request in flight, drives datapath commands
	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	// storage, status decision and response register
	brb_dp #(
		.SLOTS   (SLOTS),
		.READERS (READERS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_slots   (slots_cfg_q),
		.cfg_readers (readers_cfg_q),
		.req         (req),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

endmodule
